// File: sv/bscf_pkg.sv
// bscf_pkg: shared types and constants for the bitmap set/count/find-first unit
// no dependencies; imported by every bscf module
`default_nettype none

package bscf_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned OFF_W     = 5;
  localparam logic [WORD_BITS-1:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    OP_SET       = 3'd0,
    OP_CLEAR     = 3'd1,
    OP_TOGGLE    = 3'd2,
    OP_TEST      = 3'd3,
    OP_CLEAR_ALL = 3'd4,
    OP_SET_ALL   = 3'd5,
    OP_COUNT     = 3'd6,
    OP_FIND      = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_UPDATE,
    ST_FILL,
    ST_SCAN
  } state_t;

  // control into the shared word unit
  typedef struct packed {
    op_t              op;
    logic [OFF_W-1:0] bit_off;
  } unit_ctl_t;

  // everything the word unit derives from one word
  typedef struct packed {
    logic [WORD_BITS-1:0] live;
    logic [WORD_BITS-1:0] updated;
    logic                 test;
    logic [OFF_W:0]       pop;
    logic                 hit;
    logic [OFF_W-1:0]     first;
  } unit_res_t;

endpackage

`default_nettype wire

// File: sv/bscf_store.sv
// bscf_store: word memory of the bitmap, one write port and one registered read port
// depends on bscf_pkg for the word width
`default_nettype none

module bscf_store
  import bscf_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic [WORD_BITS-1:0] wr_data,
  input  wire logic                 rd_en,
  input  wire logic [AW-1:0]        rd_addr,
  output logic      [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: sv/bscf_word_unit.sv
// bscf_word_unit: shared per-word logic: live mask, bit update, popcount, lowest set bit
// depends on bscf_pkg for the control and result structs
`default_nettype none

module bscf_word_unit
  import bscf_pkg::*;
#(
  parameter int unsigned AW = 5
) (
  input  wire logic [WORD_BITS-1:0] word,
  input  wire logic [AW-1:0]        word_idx,
  input  wire logic [10:0]          size,
  input  wire unit_ctl_t            ctl,
  output unit_res_t                 res
);

  localparam int unsigned CW = (AW > 6) ? AW : 6;

  logic [CW-1:0]        wi_x;
  logic [CW-1:0]        hi_x;
  logic [OFF_W-1:0]     rem;
  logic [WORD_BITS-1:0] live;
  logic [WORD_BITS-1:0] masked;
  logic [WORD_BITS-1:0] onehot;

  function automatic logic [OFF_W:0] pop32(input logic [WORD_BITS-1:0] x);
    logic [1:0] l1 [16];
    logic [2:0] l2 [8];
    logic [3:0] l3 [4];
    logic [4:0] l4 [2];
    for (int i = 0; i < 16; i++) l1[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
    for (int i = 0; i < 8; i++)  l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    for (int i = 0; i < 4; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    for (int i = 0; i < 2; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    return {1'b0, l4[0]} + {1'b0, l4[1]};
  endfunction

  // binary search for the lowest set bit, halving the window each step
  function automatic logic [OFF_W-1:0] ffs32(input logic [WORD_BITS-1:0] x);
    logic [WORD_BITS-1:0] v;
    logic [OFF_W-1:0]     pos;
    v   = x;
    pos = '0;
    for (int s = OFF_W - 1; s >= 0; s--) begin
      if ((v & ((32'd1 << (1 << s)) - 32'd1)) == '0) begin
        pos[s] = 1'b1;
        v      = v >> (1 << s);
      end
    end
    return pos;
  endfunction

  assign wi_x = CW'(word_idx);
  assign hi_x = CW'(size[10:5]);
  assign rem  = size[4:0];

  // bits of this word that lie below the configured size
  always_comb begin
    if (wi_x < hi_x) begin
      live = ALL_ONES;
    end else if (wi_x == hi_x && rem != '0) begin
      live = WORD_BITS'((33'd1 << rem) - 33'd1);
    end else begin
      live = '0;
    end
  end

  assign masked = word & live;
  assign onehot = WORD_BITS'(1) << ctl.bit_off;

  always_comb begin
    res.live  = live;
    res.test  = word[ctl.bit_off];
    res.pop   = pop32(masked);
    res.hit   = (masked != '0);
    res.first = ffs32(masked);
    case (ctl.op)
      OP_SET:    res.updated = word | onehot;
      OP_CLEAR:  res.updated = word & ~onehot;
      OP_TOGGLE: res.updated = word ^ onehot;
      default:   res.updated = word;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/bitmap_set_count_find_first_unit.sv
// bitmap_set_count_find_first_unit: top level, sequencer around the word store and word unit
// depends on bscf_pkg, bscf_store and bscf_word_unit
//
// A request is taken when start is high and busy is low, and its one result appears on
// test_bit, population, found and first_index for a single cycle with done high; the
// receiver cannot stall. Set, clear, toggle and test read their word as the request is
// taken, then update or test it in ST_UPDATE, which sets the registered done. Count and
// find first read the store one word per cycle through the single read port, nw =
// ceil(bit_count/32) words in all; find first stops at the first word with a live set bit.
// Clear all and set all write one word per cycle, nw words in all. A new request can be
// taken in the cycle that carries done. After reset a clearing pass writes all MAX_BITS/32
// words (rounded up) one per cycle with busy high; bit_count writes are taken at any time
// but belong to idle periods.
`default_nettype none

module bitmap_set_count_find_first_unit
  import bscf_pkg::*;
#(
  parameter int unsigned MAX_BITS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  opcode,
  input  wire logic [9:0]  bit_index,
  input  wire logic        bit_count_we,
  input  wire logic [10:0] bit_count,
  output logic             done,
  output logic             test_bit,
  output logic [10:0]      population,
  output logic             found,
  output logic [9:0]       first_index
);

  localparam int unsigned NUM_WORDS = (MAX_BITS + 31) / 32;
  localparam int unsigned AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned WC = $clog2(NUM_WORDS + 1);
  localparam int unsigned CW = (WC > 7) ? WC : 7;
  localparam int unsigned RESET_SIZE = (MAX_BITS < 1024) ? MAX_BITS : 1024;

  state_t          state, state_next;
  logic [10:0]     size;
  op_t             op_q, op_next;
  logic [9:0]      idx_q, idx_next;
  logic [WC-1:0]   cnt, cnt_next;
  logic            pv, pv_next;
  logic [AW-1:0]   pw, pw_next;
  logic [10:0]     acc, acc_next;
  logic            done_next;
  logic            test_bit_next;
  logic [10:0]     population_next;
  logic            found_next;
  logic [9:0]      first_index_next;

  logic [6:0]      nw;
  logic [CW-1:0]   nw_x;
  logic [CW-1:0]   cnt_x;
  logic [CW-1:0]   pw_x;
  logic            port_in_range;
  logic            q_in_range;
  logic [15:0]     port_word;
  logic [15:0]     q_word;
  logic [20:0]     found_pos;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic [AW-1:0]        unit_idx;
  unit_ctl_t            unit_ctl;
  unit_res_t            unit_res;

  bscf_store #(
    .DEPTH (NUM_WORDS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bscf_word_unit #(
    .AW (AW)
  ) u_word (
    .word     (rd_data),
    .word_idx (unit_idx),
    .size     (size),
    .ctl      (unit_ctl),
    .res      (unit_res)
  );

  assign nw            = 7'((12'(size) + 12'd31) >> 5);
  assign nw_x          = CW'(nw);
  assign cnt_x         = CW'(cnt);
  assign pw_x          = CW'(pw);
  assign port_in_range = ({1'b0, bit_index} < size);
  assign q_in_range    = ({1'b0, idx_q} < size);
  assign port_word     = {11'd0, bit_index[9:5]};
  assign q_word        = {11'd0, idx_q[9:5]};
  assign found_pos     = {16'(pw), unit_res.first};
  assign busy          = (state != ST_IDLE);

  assign unit_ctl.op      = op_q;
  assign unit_ctl.bit_off = idx_q[4:0];

  always_comb begin
    state_next       = state;
    op_next          = op_q;
    idx_next         = idx_q;
    cnt_next         = cnt;
    pv_next          = pv;
    pw_next          = pw;
    acc_next         = acc;
    done_next        = 1'b0;
    test_bit_next    = test_bit;
    population_next  = population;
    found_next       = found;
    first_index_next = first_index;
    wr_en            = 1'b0;
    wr_addr          = cnt[AW-1:0];
    wr_data          = '0;
    rd_en            = 1'b0;
    rd_addr          = cnt[AW-1:0];
    unit_idx         = cnt[AW-1:0];

    case (state)
      ST_INIT: begin
        wr_en    = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == WC'(NUM_WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        // single-bit ops read their word while the beat is taken
        rd_addr = port_word[AW-1:0];
        rd_en   = start && port_in_range;
        if (start) begin
          op_next  = op_t'(opcode);
          idx_next = bit_index;
          cnt_next = '0;
          pv_next  = 1'b0;
          acc_next = '0;
          case (op_t'(opcode))
            OP_CLEAR_ALL, OP_SET_ALL: state_next = ST_FILL;
            OP_COUNT, OP_FIND:        state_next = ST_SCAN;
            default:                  state_next = ST_UPDATE;
          endcase
        end
      end

      ST_UPDATE: begin
        wr_addr          = q_word[AW-1:0];
        wr_data          = unit_res.updated;
        wr_en            = q_in_range &&
                           (op_q == OP_SET || op_q == OP_CLEAR || op_q == OP_TOGGLE);
        done_next        = 1'b1;
        test_bit_next    = (op_q == OP_TEST) && q_in_range && unit_res.test;
        population_next  = '0;
        found_next       = 1'b0;
        first_index_next = '0;
        state_next       = ST_IDLE;
      end

      ST_FILL: begin
        wr_data = (op_q == OP_SET_ALL) ? unit_res.live : '0;
        if (cnt_x < nw_x) begin
          wr_en    = 1'b1;
          cnt_next = cnt + 1'b1;
        end
        if (nw_x == '0 || cnt_x == nw_x - 1'b1) begin
          done_next        = 1'b1;
          test_bit_next    = 1'b0;
          population_next  = '0;
          found_next       = 1'b0;
          first_index_next = '0;
          state_next       = ST_IDLE;
        end
      end

      ST_SCAN: begin
        // reads run one word ahead of the unit; pv marks data on rd_data
        unit_idx = pw;
        if (cnt_x < nw_x) begin
          rd_en    = 1'b1;
          cnt_next = cnt + 1'b1;
        end
        pv_next = (cnt_x < nw_x);
        pw_next = cnt[AW-1:0];
        if (pv) begin
          acc_next = acc + 11'(unit_res.pop);
        end
        if (nw_x == '0) begin
          done_next        = 1'b1;
          test_bit_next    = 1'b0;
          population_next  = '0;
          found_next       = 1'b0;
          first_index_next = '0;
          pv_next          = 1'b0;
          state_next       = ST_IDLE;
        end else if (pv && op_q == OP_FIND && unit_res.hit) begin
          done_next        = 1'b1;
          test_bit_next    = 1'b0;
          population_next  = '0;
          found_next       = 1'b1;
          first_index_next = found_pos[9:0];
          pv_next          = 1'b0;
          state_next       = ST_IDLE;
        end else if (pv && pw_x == nw_x - 1'b1) begin
          done_next        = 1'b1;
          test_bit_next    = 1'b0;
          population_next  = (op_q == OP_COUNT) ? acc + 11'(unit_res.pop) : '0;
          found_next       = 1'b0;
          first_index_next = '0;
          pv_next          = 1'b0;
          state_next       = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      cnt   <= '0;
      pv    <= 1'b0;
      done  <= 1'b0;
      size  <= 11'(RESET_SIZE);
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pv    <= pv_next;
      done  <= done_next;
      if (bit_count_we) begin
        // sizes above the store saturate
        if (17'(bit_count) > 17'(MAX_BITS)) begin
          size <= 11'(MAX_BITS);
        end else begin
          size <= bit_count;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    op_q        <= op_next;
    idx_q       <= idx_next;
    pw          <= pw_next;
    acc         <= acc_next;
    test_bit    <= test_bit_next;
    population  <= population_next;
    found       <= found_next;
    first_index <= first_index_next;
  end

endmodule

`default_nettype wire

// File: tb/bitmap_set_count_find_first_unit_tb.sv
// bitmap_set_count_find_first_unit_tb: self-checking testbench for the bitmap unit
// holds a shadow bitmap that predicts every result; directed tests, then random phases
// depends on bscf_pkg and bitmap_set_count_find_first_unit
module bitmap_set_count_find_first_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bscf_pkg::*;

  localparam int unsigned MAX_BITS  = 1024;
  localparam int unsigned NUM_WORDS = (MAX_BITS + 31) / 32;

  typedef struct packed {
    logic        test_bit;
    logic [10:0] population;
    logic        found;
    logic [9:0]  first_index;
  } bitmap_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  opcode;
  logic [9:0]  bit_index;
  logic        bit_count_we;
  logic [10:0] bit_count;
  logic        done;
  logic        test_bit;
  logic [10:0] population;
  logic        found;
  logic [9:0]  first_index;

  logic [31:0]    shadow_words [NUM_WORDS];
  int unsigned    shadow_size;
  bitmap_result_t expected_results [$];
  bitmap_result_t oldest_result;
  int unsigned    fail_count = 0;
  bit             gaps_enabled = 1'b1;

  bitmap_set_count_find_first_unit #(
    .MAX_BITS(MAX_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .bit_index(bit_index),
    .bit_count_we(bit_count_we),
    .bit_count(bit_count),
    .done(done),
    .test_bit(test_bit),
    .population(population),
    .found(found),
    .first_index(first_index)
  );

  always #10 clk = ~clk;

  // bits of word w that lie below the configured size
  function automatic logic [31:0] live_mask(int unsigned w, int unsigned size);
    int unsigned base;
    base = w * 32;
    if (size >= base + 32) return '1;
    if (size <= base) return '0;
    return (32'd1 << (size - base)) - 32'd1;
  endfunction

  // apply one request to the shadow bitmap and queue the result it yields
  task automatic predict_request(op_t op, logic [9:0] idx);
    bitmap_result_t r;
    int unsigned    nw;
    int unsigned    wi;
    int unsigned    rem;
    logic [31:0]    m;
    logic [31:0]    x;
    bit             in_range;
    bit             hit;
    r        = '0;
    nw       = (shadow_size + 31) / 32;
    wi       = 32'(idx[9:5]);
    m        = 32'd1 << idx[4:0];
    in_range = 32'(idx) < shadow_size;
    hit      = 1'b0;
    case (op)
      OP_SET:    if (in_range) shadow_words[wi] |= m;
      OP_CLEAR:  if (in_range) shadow_words[wi] &= ~m;
      OP_TOGGLE: if (in_range) shadow_words[wi] ^= m;
      OP_TEST:   if (in_range) r.test_bit = (shadow_words[wi] & m) != 0;
      OP_CLEAR_ALL: begin
        for (int unsigned w = 0; w < nw; w++) shadow_words[w] = '0;
      end
      OP_SET_ALL: begin
        if (shadow_size != 0) begin
          for (int unsigned w = 0; w < nw; w++) shadow_words[w] = '1;
          rem = shadow_size & 31;
          if (rem != 0) shadow_words[nw-1] = (32'd1 << rem) - 32'd1;
        end
      end
      OP_COUNT: begin
        for (int unsigned w = 0; w < nw; w++)
          r.population += 11'($countones(shadow_words[w] & live_mask(w, shadow_size)));
      end
      default: begin
        for (int unsigned w = 0; w < nw; w++) begin
          x = shadow_words[w] & live_mask(w, shadow_size);
          for (int unsigned b = 0; b < 32; b++) begin
            if (!hit && x[b]) begin
              hit           = 1'b1;
              r.found       = 1'b1;
              r.first_index = 10'(w * 32 + b);
            end
          end
        end
      end
    endcase
    expected_results.push_back(r);
  endtask

  task automatic idle_cycles(int unsigned n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // drive one beat and hold it until the block takes it
  task automatic issue_request(op_t op, logic [9:0] idx);
    int unsigned gap;
    @(negedge clk);
    start     <= 1'b1;
    opcode    <= op;
    bit_index <= idx;
    do @(posedge clk); while (busy);
    predict_request(op, idx);
    gap = gaps_enabled ? pick_gap() : 0;
    if (gap != 0) idle_cycles(gap);
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_bit_count(logic [10:0] value);
    wait_results_drained();
    bit_count_we <= 1'b1;
    bit_count    <= value;
    @(negedge clk);
    bit_count_we <= 1'b0;
    shadow_size = (32'(value) > MAX_BITS) ? MAX_BITS : 32'(value);
  endtask

  task automatic test_single_bit_ops();
    write_bit_count(11'd1024);
    issue_request(OP_SET, 10'd0);
    issue_request(OP_SET, 10'd1023);
    issue_request(OP_TEST, 10'd0);
    issue_request(OP_TEST, 10'd1023);
    issue_request(OP_TEST, 10'd512);
    issue_request(OP_TOGGLE, 10'd1023);
    issue_request(OP_TOGGLE, 10'd700);
    issue_request(OP_CLEAR, 10'd0);
    issue_request(OP_FIND, 10'd0);
    issue_request(OP_COUNT, 10'd1023);
  endtask

  task automatic test_whole_store_ops();
    issue_request(OP_SET_ALL, 10'd0);
    issue_request(OP_COUNT, 10'd0);
    issue_request(OP_FIND, 10'd0);
    issue_request(OP_CLEAR_ALL, 10'd0);
    issue_request(OP_COUNT, 10'd0);
    issue_request(OP_FIND, 10'd0);
  endtask

  task automatic test_resize();
    // partial final word after set all, then stale bits from a larger size
    write_bit_count(11'd40);
    issue_request(OP_SET_ALL, 10'd0);
    write_bit_count(11'd1024);
    issue_request(OP_COUNT, 10'd0);
    issue_request(OP_SET, 10'd1000);
    write_bit_count(11'd40);
    issue_request(OP_SET, 10'd1001);
    issue_request(OP_TEST, 10'd1000);
    issue_request(OP_COUNT, 10'd0);
    write_bit_count(11'd0);
    issue_request(OP_SET_ALL, 10'd0);
    issue_request(OP_FIND, 10'd0);
    issue_request(OP_TEST, 10'd0);
    // above the maximum saturates
    write_bit_count(11'd2047);
    issue_request(OP_COUNT, 10'd0);
  endtask

  task automatic test_random_phases();
    int unsigned size_value;
    int unsigned r;
    op_t         op;
    logic [9:0]  idx;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: size_value = 1024;
        1: size_value = 0;
        2: size_value = 1;
        3: size_value = 31;
        4: size_value = 32;
        5: size_value = 33;
        6: size_value = 1023;
        7: size_value = 2047;
        8: size_value = $urandom_range(2, 200);
        default: size_value = $urandom_range(0, 2047);
      endcase
      write_bit_count(size_value[10:0]);
      gaps_enabled = (phase != 4);
      if ($urandom_range(0, 4) != 0) issue_request(OP_CLEAR_ALL, 10'd0);
      for (int i = 0; i < 130; i++) begin
        r = $urandom_range(0, 99);
        if (r < 72) op = op_t'($urandom_range(0, 3));
        else if (r < 86) op = ($urandom_range(0, 1) != 0) ? OP_COUNT : OP_FIND;
        else if (r < 93) op = OP_CLEAR_ALL;
        else op = OP_SET_ALL;
        if (shadow_size != 0 && $urandom_range(0, 3) != 0)
          idx = 10'($urandom_range(0, shadow_size - 1));
        else
          idx = 10'($urandom_range(0, 1023));
        issue_request(op, idx);
        // hold off now and then until the block has answered everything
        if (i == 65 || $urandom_range(0, 39) == 0) wait_results_drained();
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result beat: test_bit=%0d population=%0d found=%0d %s%0d",
                   test_bit, population, found, "first_index=", first_index);
      end else begin
        oldest_result = expected_results.pop_front();
        if (test_bit !== oldest_result.test_bit || population !== oldest_result.population ||
            found !== oldest_result.found || first_index !== oldest_result.first_index) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch: expected test_bit=%0d population=%0d found=%0d first_index=%0d",
                     oldest_result.test_bit, oldest_result.population, oldest_result.found,
                     oldest_result.first_index);
            $display("          got      test_bit=%0d population=%0d found=%0d first_index=%0d",
                     test_bit, population, found, first_index);
          end
        end
      end
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    opcode       = OP_SET;
    bit_index    = '0;
    bit_count_we = 1'b0;
    bit_count    = '0;
    for (int w = 0; w < NUM_WORDS; w++) shadow_words[w] = '0;
    shadow_size = MAX_BITS;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_bit_ops();
    test_whole_store_ops();
    test_resize();
    test_random_phases();

    wait_results_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
